[design/cfe_pkg.sv]
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and helpers for the cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int MAX_BUCKETS = 256;
   localparam int PHYS_SLOTS  = 8;
   localparam int BKT_W       = $clog2(MAX_BUCKETS);
   localparam int SLOT_W      = $clog2(PHYS_SLOTS);
   localparam int ADDR_W      = BKT_W + SLOT_W;
   localparam int TOTAL_SLOTS = MAX_BUCKETS * PHYS_SLOTS;

   localparam int HASH_W  = 64;
   localparam int FP_W    = 16;
   localparam int DIV_W   = HASH_W - FP_W;
   localparam int DIV_CW  = $clog2(DIV_W);
   localparam int CNT_W   = 9;
   localparam int ITEM_W  = 12;
   localparam int FILL_W  = 4;
   localparam int SPB_W   = 4;
   localparam int THR_W   = 11;
   localparam int KICK_W  = 10;
   localparam int SCR_W   = ADDR_W + 1;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 11;
   localparam int QDEPTH  = 2;

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [HASH_W-1:0] FNV_LOW   = 64'h1b3;
   localparam int                FNV_SHIFT = 40;
   localparam logic [31:0]       ALT_MUL   = 32'h5bd1e995;
   localparam logic [15:0]       LFSR_SEED = 16'hACE1;

   localparam logic [CSR_AW-1:0] CFG_INIT_BUCKETS = 2'd0;
   localparam logic [CSR_AW-1:0] CFG_SLOTS        = 2'd1;
   localparam logic [CSR_AW-1:0] CFG_THRESHOLD    = 2'd2;
   localparam logic [CSR_AW-1:0] CFG_MAX_KICKS    = 2'd3;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic              func;
   } key_entry_type;

   typedef struct packed {
      logic              we;
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

   typedef struct packed {
      logic [CNT_W-1:0]  bucket_count;
      logic [ITEM_W-1:0] item_count;
      logic              overflow;
      logic              expanded;
      logic              inserted;
      logic              found;
   } result_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_LK_I1, ST_LK_S1, ST_LK_S2, ST_SC_F, ST_SC_N, ST_SC_R, ST_SC_C,
      ST_DECIDE, ST_LD_M1, ST_LD_M2, ST_LD_C,
      ST_RB_START, ST_RB_F, ST_RB_N, ST_RB_S, ST_RB_W, ST_RB_END, ST_RB_L, ST_RB_R,
      ST_PK_I1, ST_PK_A, ST_PK_B, ST_PK_C, ST_PK_D,
      ST_KK_T, ST_KK_N, ST_KK_S, ST_KK_X, ST_KK_P, ST_KK_V, ST_KK_U, ST_KK_Q, ST_KK_Z,
      ST_FIN, ST_PLACE, ST_PK_RET, ST_ALTM, ST_ALTD, ST_DIVW, ST_RESP
   } state_type;

   function automatic logic [FP_W-1:0] fp_of(input logic [HASH_W-1:0] h);
      logic [FP_W-1:0] f;
      f = h[FP_W-1:0];
      return (f == '0) ? FP_W'(1) : f;
   endfunction

   function automatic logic [15:0] lfsr_step(input logic [15:0] v);
      logic b;
      b = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {b, v[15:1]};
   endfunction

endpackage

[design/cfe_front.sv]
// ----------------------------------------------------------------------------
// cfe_front
// Folds key bytes into a 64-bit FNV-1a hash and queues finished keys.
// ----------------------------------------------------------------------------
module cfe_front
   import cfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_func,
   input  logic [7:0]    in_byte,
   input  logic          in_byte_valid,
   input  logic          in_last,
   input  logic          q_full,
   output logic          q_push,
   output key_entry_type q_entry
);

   logic [HASH_W-1:0] acc_ff, acc_in;
   logic [HASH_W-1:0] mixed, hashed;
   logic              accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign mixed    = acc_ff ^ {{(HASH_W-8){1'b0}}, in_byte};
   assign hashed   = in_byte_valid ? ((mixed << FNV_SHIFT) + (mixed * FNV_LOW)) : acc_ff;

   always_comb begin
      acc_in        = acc_ff;
      q_push        = 1'b0;
      q_entry.hash  = hashed;
      q_entry.func  = in_func;
      if (accept) begin
         if (in_last) begin
            acc_in = FNV_BASIS;
            q_push = 1'b1;
         end else begin
            acc_in = hashed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= FNV_BASIS;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[design/cfe_fifo.sv]
// ----------------------------------------------------------------------------
// cfe_fifo
// Short key queue between the hashing front and the filter back end.
// ----------------------------------------------------------------------------
module cfe_fifo
   import cfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  key_entry_type push_data,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output key_entry_type head
);

   localparam int PTR_W = $clog2(QDEPTH);

   key_entry_type            mem_ff [QDEPTH];
   logic [PTR_W-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]           cnt_ff, cnt_in;

   assign full      = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[design/cfe_mod.sv]
// ----------------------------------------------------------------------------
// cfe_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cfe_mod
   import cfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mod_req_type      req,
   output mod_stat_type     stat,
   output logic [CNT_W-1:0] rem
);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]    dvd_ff, dvd_in;
   logic [CNT_W-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W:0]      trial;

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;
   assign trial     = {rem_ff, dvd_ff[DIV_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = CNT_W'(trial);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

endmodule

[design/cfe_back.sv]
// ----------------------------------------------------------------------------
// cfe_back
// Filter sequencer: lookup, load check, rebuild and cuckoo eviction.
// ----------------------------------------------------------------------------
module cfe_back
   import cfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  csr_wr_type       csr,
   input  logic             q_valid,
   input  key_entry_type    q_head,
   output logic             q_pop,
   output mod_req_type      mod_req,
   input  mod_stat_type     mod_stat,
   input  logic [CNT_W-1:0] mod_rem,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_data
);

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [HASH_W-1:0] key_h_ff, key_h_in, car_h_ff, car_h_in;
   logic              func_ff, func_in;
   logic [BKT_W-1:0]  i1_ff, i1_in, i2_ff, i2_in, sb_ff, sb_in, base_ff, base_in;
   logic [BKT_W-1:0]  cur_ff, cur_in, pb_ff, pb_in;
   logic              scan2_ff, scan2_in;
   logic [FILL_W-1:0] n_ff, n_in, s_ff, s_in, pn_ff, pn_in;
   logic              found_ff, found_in, ins_ff, ins_in, exp_ff, exp_in, ovf_ff, ovf_in;
   logic [DIV_W-1:0]  prod_ff, prod_in;
   logic [19:0]       thr_b_ff, thr_b_in;
   logic [23:0]       rhs_ff, rhs_in;
   logic              rbmode_ff, rbmode_in, rbok_ff, rbok_in, pkok_ff, pkok_in;
   logic [CNT_W-1:0]  b_ff, b_in;
   logic [SCR_W-1:0]  cnt_ff, cnt_in, idx_ff, idx_in;
   logic [KICK_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] sidx_ff, sidx_in;
   logic [15:0]       lfsr_ff, lfsr_in, lfsr_nx;
   logic [CNT_W-1:0]  bkt_ff, bkt_in;
   logic [ITEM_W-1:0] items_ff, items_in;
   logic [SPB_W-1:0]  spb_ff, spb_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [KICK_W-1:0] kicks_ff, kicks_in;
   logic [CNT_W-1:0]  initb_ff, initb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
   logic [FILL_W-1:0] fill_rd_ff, fill_q, fill_wd;
   logic              fill_vrd_ff;
   logic [MAX_BUCKETS-1:0] fill_vld_ff, fill_vld_in;
   logic [BKT_W-1:0]  fill_ra, fill_wa;
   logic              fill_we, fill_clr;

   logic [HASH_W-1:0] slot_mem [TOTAL_SLOTS];
   logic [HASH_W-1:0] slot_q, slot_wd;
   logic [ADDR_W-1:0] slot_ra, slot_wa;
   logic              slot_we;

   logic [HASH_W-1:0] scr_mem [TOTAL_SLOTS];
   logic [HASH_W-1:0] scr_q;
   logic [ADDR_W-1:0] scr_ra, scr_wa;
   logic              scr_we;

   logic [FP_W-1:0]   car_fp;
   logic [CNT_W-1:0]  cfg_b;
   logic [SPB_W-1:0]  cfg_s;
   logic [THR_W-1:0]  cfg_t;

   assign car_fp    = fp_of(car_h_ff);
   assign fill_q    = fill_vrd_ff ? fill_rd_ff : '0;
   assign lfsr_nx   = lfsr_step(lfsr_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      cfg_b = csr.data[CNT_W-1:0];
      if (cfg_b == '0) cfg_b = CNT_W'(1);
      if (cfg_b > CNT_W'(MAX_BUCKETS)) cfg_b = CNT_W'(MAX_BUCKETS);
      cfg_s = csr.data[SPB_W-1:0];
      if (cfg_s == '0) cfg_s = SPB_W'(1);
      if (cfg_s > SPB_W'(PHYS_SLOTS)) cfg_s = SPB_W'(PHYS_SLOTS);
      cfg_t = csr.data[THR_W-1:0];
      if (cfg_t == '0) cfg_t = THR_W'(1);
   end

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;
      key_h_in = key_h_ff;   car_h_in = car_h_ff;  func_in = func_ff;
      i1_in = i1_ff;  i2_in = i2_ff;  sb_in = sb_ff;  base_in = base_ff;
      cur_in = cur_ff;  pb_in = pb_ff;  scan2_in = scan2_ff;
      n_in = n_ff;  s_in = s_ff;  pn_in = pn_ff;
      found_in = found_ff;  ins_in = ins_ff;  exp_in = exp_ff;  ovf_in = ovf_ff;
      prod_in = prod_ff;  thr_b_in = thr_b_ff;  rhs_in = rhs_ff;
      rbmode_in = rbmode_ff;  rbok_in = rbok_ff;  pkok_in = pkok_ff;
      b_in = b_ff;  cnt_in = cnt_ff;  idx_in = idx_ff;  k_in = k_ff;  sidx_in = sidx_ff;
      lfsr_in = lfsr_ff;  bkt_in = bkt_ff;  items_in = items_ff;
      spb_in = spb_ff;  thr_in = thr_ff;  kicks_in = kicks_ff;  initb_in = initb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      mod_req.go = 1'b0;
      mod_req.dividend = car_h_ff[HASH_W-1:FP_W];
      mod_req.divisor = bkt_ff;
      fill_ra = sb_ff;  fill_we = 1'b0;  fill_wa = pb_ff;
      fill_wd = pn_ff + 1'b1;  fill_clr = 1'b0;
      slot_ra = {sb_ff, s_ff[SLOT_W-1:0]};  slot_we = 1'b0;
      slot_wa = {pb_ff, pn_ff[SLOT_W-1:0]};  slot_wd = car_h_ff;
      scr_ra = idx_ff[ADDR_W-1:0];  scr_we = 1'b0;  scr_wa = cnt_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop = 1'b1;
               key_h_in = q_head.hash;  car_h_in = q_head.hash;  func_in = q_head.func;
               found_in = 1'b0;  ins_in = 1'b0;  exp_in = 1'b0;  ovf_in = 1'b0;
               state_in = ST_LK_I1;
            end
         end
         ST_LK_I1: begin
            mod_req.go = 1'b1;  ret_in = ST_LK_S1;  state_in = ST_DIVW;
         end
         ST_LK_S1: begin
            i1_in = mod_rem[BKT_W-1:0];  sb_in = mod_rem[BKT_W-1:0];
            scan2_in = 1'b0;  state_in = ST_SC_F;
         end
         ST_LK_S2: begin
            i2_in = mod_rem[BKT_W-1:0];  sb_in = mod_rem[BKT_W-1:0];
            scan2_in = 1'b1;  state_in = ST_SC_F;
         end
         ST_SC_F: state_in = ST_SC_N;
         ST_SC_N: begin
            n_in = fill_q;  s_in = '0;  state_in = ST_SC_R;
         end
         ST_SC_R: begin
            if (s_ff == n_ff) begin
               if (!scan2_ff) begin
                  base_in = i1_ff;  ret_in = ST_LK_S2;  state_in = ST_ALTM;
               end else begin
                  state_in = ST_DECIDE;
               end
            end else begin
               state_in = ST_SC_C;
            end
         end
         ST_SC_C: begin
            if (fp_of(slot_q) == car_fp) begin
               found_in = 1'b1;  state_in = ST_DECIDE;
            end else begin
               s_in = s_ff + 1'b1;  state_in = ST_SC_R;
            end
         end
         ST_DECIDE: state_in = (func_ff && !found_ff) ? ST_LD_M1 : ST_RESP;
         ST_LD_M1: begin
            thr_b_in = thr_ff * bkt_ff;  state_in = ST_LD_M2;
         end
         ST_LD_M2: begin
            rhs_in = thr_b_ff * spb_ff;  state_in = ST_LD_C;
         end
         ST_LD_C: begin
            if ({4'b0, items_ff, 8'b0} >= rhs_ff) begin
               if (({1'b0, bkt_ff} << 1) > (CNT_W+1)'(MAX_BUCKETS)) begin
                  ovf_in = 1'b1;  state_in = ST_RESP;
               end else begin
                  exp_in = 1'b1;  state_in = ST_RB_START;
               end
            end else begin
               car_h_in = key_h_ff;  rbmode_in = 1'b0;  state_in = ST_PK_I1;
            end
         end
         ST_RB_START: begin
            b_in = '0;  cnt_in = '0;  state_in = ST_RB_F;
         end
         ST_RB_F: begin
            fill_ra = b_ff[BKT_W-1:0];
            state_in = (b_ff == bkt_ff) ? ST_RB_END : ST_RB_N;
         end
         ST_RB_N: begin
            n_in = fill_q;  s_in = '0;  state_in = ST_RB_S;
         end
         ST_RB_S: begin
            slot_ra = {b_ff[BKT_W-1:0], s_ff[SLOT_W-1:0]};
            if (s_ff == n_ff) begin
               b_in = b_ff + 1'b1;  state_in = ST_RB_F;
            end else begin
               state_in = ST_RB_W;
            end
         end
         ST_RB_W: begin
            scr_we = 1'b1;  cnt_in = cnt_ff + 1'b1;  s_in = s_ff + 1'b1;
            state_in = ST_RB_S;
         end
         ST_RB_END: begin
            bkt_in = CNT_W'({1'b0, bkt_ff} << 1);
            fill_clr = 1'b1;  items_in = '0;  idx_in = '0;  rbok_in = 1'b1;
            state_in = ST_RB_L;
         end
         ST_RB_L: begin
            if (idx_ff == cnt_ff) begin
               if (!rbok_ff) ovf_in = 1'b1;
               car_h_in = key_h_ff;  rbmode_in = 1'b0;  state_in = ST_PK_I1;
            end else begin
               state_in = ST_RB_R;
            end
         end
         ST_RB_R: begin
            car_h_in = scr_q;  rbmode_in = 1'b1;  state_in = ST_PK_I1;
         end
         ST_PK_I1: begin
            mod_req.go = 1'b1;  ret_in = ST_PK_A;  state_in = ST_DIVW;
         end
         ST_PK_A: begin
            i1_in = mod_rem[BKT_W-1:0];  fill_ra = mod_rem[BKT_W-1:0];
            state_in = ST_PK_B;
         end
         ST_PK_B: begin
            if (fill_q < spb_ff) begin
               pb_in = i1_ff;  pn_in = fill_q;  state_in = ST_PLACE;
            end else begin
               base_in = i1_ff;  ret_in = ST_PK_C;  state_in = ST_ALTM;
            end
         end
         ST_PK_C: begin
            i2_in = mod_rem[BKT_W-1:0];  fill_ra = mod_rem[BKT_W-1:0];
            state_in = ST_PK_D;
         end
         ST_PK_D: begin
            if (fill_q < spb_ff) begin
               pb_in = i2_ff;  pn_in = fill_q;  state_in = ST_PLACE;
            end else begin
               lfsr_in = lfsr_nx;
               cur_in = lfsr_nx[0] ? i2_ff : i1_ff;
               k_in = '0;  state_in = ST_KK_T;
            end
         end
         ST_KK_T: begin
            fill_ra = cur_ff;
            state_in = (k_ff == kicks_ff) ? ST_FIN : ST_KK_N;
         end
         ST_FIN: begin
            if (fill_q < FILL_W'(PHYS_SLOTS)) begin
               pb_in = cur_ff;  pn_in = fill_q;  state_in = ST_PLACE;
            end else begin
               pkok_in = 1'b0;  state_in = ST_PK_RET;
            end
         end
         ST_KK_N: begin
            if (fill_q == '0) begin
               pb_in = cur_ff;  pn_in = '0;  state_in = ST_PLACE;
            end else begin
               lfsr_in = lfsr_nx;
               mod_req.go = 1'b1;
               mod_req.dividend = DIV_W'(lfsr_nx);
               mod_req.divisor = CNT_W'(fill_q);
               ret_in = ST_KK_S;  state_in = ST_DIVW;
            end
         end
         ST_KK_S: begin
            slot_ra = {cur_ff, mod_rem[SLOT_W-1:0]};
            sidx_in = {cur_ff, mod_rem[SLOT_W-1:0]};
            state_in = ST_KK_X;
         end
         ST_KK_X: begin
            slot_we = 1'b1;  slot_wa = sidx_ff;  slot_wd = car_h_ff;
            car_h_in = slot_q;  state_in = ST_KK_P;
         end
         ST_KK_P: begin
            mod_req.go = 1'b1;  ret_in = ST_KK_V;  state_in = ST_DIVW;
         end
         ST_KK_V: begin
            if (cur_ff == mod_rem[BKT_W-1:0]) begin
               base_in = mod_rem[BKT_W-1:0];  ret_in = ST_KK_U;  state_in = ST_ALTM;
            end else begin
               cur_in = mod_rem[BKT_W-1:0];  state_in = ST_KK_Q;
            end
         end
         ST_KK_U: begin
            cur_in = mod_rem[BKT_W-1:0];  state_in = ST_KK_Q;
         end
         ST_KK_Q: begin
            fill_ra = cur_ff;  state_in = ST_KK_Z;
         end
         ST_KK_Z: begin
            if (fill_q < spb_ff) begin
               pb_in = cur_ff;  pn_in = fill_q;  state_in = ST_PLACE;
            end else begin
               k_in = k_ff + 1'b1;  state_in = ST_KK_T;
            end
         end
         ST_PLACE: begin
            slot_we = 1'b1;  fill_we = 1'b1;  pkok_in = 1'b1;  state_in = ST_PK_RET;
         end
         ST_PK_RET: begin
            if (rbmode_ff) begin
               if (pkok_ff) items_in = items_ff + 1'b1;
               else         rbok_in = 1'b0;
               idx_in = idx_ff + 1'b1;  state_in = ST_RB_L;
            end else begin
               if (pkok_ff) begin
                  ins_in = 1'b1;  items_in = items_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = ST_RESP;
            end
         end
         ST_ALTM: begin
            prod_in = car_fp * ALT_MUL;  state_in = ST_ALTD;
         end
         ST_ALTD: begin
            mod_req.go = 1'b1;
            mod_req.dividend = prod_ff ^ DIV_W'(base_ff);
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (mod_stat.done) state_in = ret_ff;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_in.found = found_ff;  rsp_in.inserted = ins_ff;
            rsp_in.expanded = exp_ff;  rsp_in.overflow = ovf_ff;
            rsp_in.item_count = items_ff;  rsp_in.bucket_count = bkt_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr.we) begin
         unique case (csr.addr)
            CFG_INIT_BUCKETS: begin
               initb_in = cfg_b;  bkt_in = cfg_b;  items_in = '0;  fill_clr = 1'b1;
            end
            CFG_SLOTS:     spb_in = cfg_s;
            CFG_THRESHOLD: thr_in = cfg_t;
            CFG_MAX_KICKS: kicks_in = csr.data[KICK_W-1:0];
            default: ;
         endcase
      end

      fill_vld_in = fill_vld_ff;
      if (fill_clr)     fill_vld_in = '0;
      else if (fill_we) fill_vld_in[fill_wa] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_vld_ff <= '0;
         lfsr_ff <= LFSR_SEED;
         bkt_ff <= CNT_W'(64);
         initb_ff <= CNT_W'(64);
         items_ff <= '0;
         spb_ff <= SPB_W'(4);
         thr_ff <= THR_W'(243);
         kicks_ff <= KICK_W'(500);
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_vld_ff <= fill_vld_in;
         lfsr_ff <= lfsr_in;
         bkt_ff <= bkt_in;
         initb_ff <= initb_in;
         items_ff <= items_in;
         spb_ff <= spb_in;
         thr_ff <= thr_in;
         kicks_ff <= kicks_in;
      end
   end

   always_ff @(posedge clock) begin
      key_h_ff <= key_h_in;  car_h_ff <= car_h_in;  func_ff <= func_in;
      i1_ff <= i1_in;  i2_ff <= i2_in;  sb_ff <= sb_in;  base_ff <= base_in;
      cur_ff <= cur_in;  pb_ff <= pb_in;  scan2_ff <= scan2_in;
      n_ff <= n_in;  s_ff <= s_in;  pn_ff <= pn_in;
      found_ff <= found_in;  ins_ff <= ins_in;  exp_ff <= exp_in;  ovf_ff <= ovf_in;
      prod_ff <= prod_in;  thr_b_ff <= thr_b_in;  rhs_ff <= rhs_in;
      rbmode_ff <= rbmode_in;  rbok_ff <= rbok_in;  pkok_ff <= pkok_in;
      b_ff <= b_in;  cnt_ff <= cnt_in;  idx_ff <= idx_in;  k_ff <= k_in;
      sidx_ff <= sidx_in;  rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd_ff  <= fill_mem[fill_ra];
      fill_vrd_ff <= fill_vld_in[fill_ra] & fill_vld_ff[fill_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_q <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (scr_we) scr_mem[scr_wa] <= slot_q;
      scr_q <= scr_mem[scr_ra];
   end

   a_bkt_range: assert property (@(posedge clock) disable iff (reset)
      bkt_ff != '0 && bkt_ff <= CNT_W'(MAX_BUCKETS))
      else $error("bucket count out of range");

   a_items_cap: assert property (@(posedge clock) disable iff (reset)
      items_ff <= (ITEM_W'(bkt_ff) << SLOT_W))
      else $error("item count exceeds table capacity");

   a_resp_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> rsp_valid_ff)
      else $error("result not presented");

   a_mod_idle: assert property (@(posedge clock) disable iff (reset)
      mod_req.go |-> !mod_stat.busy)
      else $error("remainder unit started while busy");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_wd != '0 && fill_wd <= FILL_W'(PHYS_SLOTS)))
      else $error("bucket fill out of range");

endmodule

[design/cuckoo_filter_engine.sv]
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Streaming cuckoo filter: FNV-1a key hashing, lookup, insert with eviction.
// ----------------------------------------------------------------------------
// Key bytes are hashed at one byte per cycle while the key queue is not full;
// a transaction with tlast queues the finished key (two-entry queue) and the
// front keeps hashing the next key. The back end handles one key at a time;
// its time is set by the shared one-bit-per-cycle remainder unit and grows
// with each slot compared, each eviction step and, on a rebuild, with one
// placement per stored item. The fill table clears through per-bucket valid
// bits, so there is no clearing pass after reset or after writing
// initial_buckets.
module cuckoo_filter_engine
   import cfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // key_byte
   input  logic [1:0]        req_tuser,   // func, byte_valid
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // found, inserted, expanded, overflow,
                                          // item_count[11:0], bucket_count[8:0]
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   logic          q_push, q_pop, q_full, q_valid;
   key_entry_type q_in, q_head;
   mod_req_type   mod_req;
   mod_stat_type  mod_stat;
   logic [CNT_W-1:0] mod_rem;
   csr_wr_type    csr;
   result_type    rsp_data;

   assign csr.we   = csr_we;
   assign csr.addr = csr_addr;
   assign csr.data = csr_wdata;
   assign rsp_tdata = {7'b0, rsp_data};

   cfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_func       (req_tuser[0]),
      .in_byte       (req_tdata),
      .in_byte_valid (req_tuser[1]),
      .in_last       (req_tlast),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_in)
   );

   cfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   cfe_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .stat  (mod_stat),
      .rem   (mod_rem)
   );

   cfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .mod_req   (mod_req),
      .mod_stat  (mod_stat),
      .mod_rem   (mod_rem),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/tb_cuckoo_filter_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cuckoo_filter_engine
// Self-checking bench for the streaming cuckoo filter engine.
// ----------------------------------------------------------------------------
// Key bytes are streamed through a queue-fed driver; a behavioral filter model
// predicts found/inserted/expanded/overflow and the counts for every key end.
// Several register settings are swept, the extremes among them, with random
// idling on both channels, one long response stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_cuckoo_filter_engine;
   import cfe_pkg::*;

   localparam int WDOG_LIMIT = 400000;
   localparam int QUIET_CYC  = 300;

   typedef enum logic [1:0] {K_BYTE, K_CFG, K_DRAIN} kind_type;

   typedef struct {
      kind_type          kind;
      logic [7:0]        kbyte;
      logic              func;
      logic              bvalid;
      logic              tlast;
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] data;
   } pend_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tlast;
   logic [7:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   cuckoo_filter_engine dut (.*);

   pend_type   pend_q[$];
   result_type want_q[$];
   int n_err, n_acc, quiet;
   bit stim_done;

   // filter model state
   logic [FP_W-1:0]   m_fp  [TOTAL_SLOTS];
   logic [HASH_W-1:0] m_hash[TOTAL_SLOTS];
   logic [HASH_W-1:0] m_scr [TOTAL_SLOTS];
   int                m_fill[MAX_BUCKETS];
   int m_nbk, m_items, m_init, m_spb, m_thr, m_kicks;
   logic [HASH_W-1:0] m_acc;
   logic [15:0]       m_lfsr;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] rnd_step();
      logic b;
      b = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
      m_lfsr = {b, m_lfsr[15:1]};
      return m_lfsr;
   endfunction

   function automatic logic [FP_W-1:0] fprint(logic [HASH_W-1:0] h);
      return (h[15:0] == 16'd0) ? 16'd1 : h[15:0];
   endfunction

   function automatic int home_bkt(logic [HASH_W-1:0] h);
      return int'((h >> 16) % 64'(m_nbk));
   endfunction

   function automatic int other_bkt(int b, logic [FP_W-1:0] f);
      return int'((64'(b) ^ (64'(f) * 64'h5bd1e995)) % 64'(m_nbk));
   endfunction

   function automatic void put_slot(int b, logic [FP_W-1:0] f, logic [HASH_W-1:0] h);
      m_fp[b*PHYS_SLOTS + m_fill[b]]   = f;
      m_hash[b*PHYS_SLOTS + m_fill[b]] = h;
      m_fill[b]++;
   endfunction

   function automatic bit bkt_has(int b, logic [FP_W-1:0] f);
      for (int s = 0; s < m_fill[b]; s++)
         if (m_fp[b*PHYS_SLOTS + s] == f) return 1;
      return 0;
   endfunction

   function automatic bit place_kick(logic [HASH_W-1:0] hin);
      logic [FP_W-1:0] f, vf;
      logic [HASH_W-1:0] h, vh;
      int i1, i2, cur, s, idx, vp;
      h = hin;
      f = fprint(h);
      i1 = home_bkt(h);
      if (m_fill[i1] < m_spb) begin put_slot(i1, f, h); return 1; end
      i2 = other_bkt(i1, f);
      if (m_fill[i2] < m_spb) begin put_slot(i2, f, h); return 1; end
      cur = (rnd_step() & 16'd1) == 0 ? i1 : i2;
      for (int k = 0; k < m_kicks; k++) begin
         if (m_fill[cur] == 0) begin put_slot(cur, f, h); return 1; end
         s = int'(rnd_step()) % m_fill[cur];
         idx = cur*PHYS_SLOTS + s;
         vf = m_fp[idx];
         vh = m_hash[idx];
         m_fp[idx] = f;
         m_hash[idx] = h;
         f = vf;
         h = vh;
         vp = home_bkt(h);
         cur = (cur == vp) ? other_bkt(vp, f) : vp;
         if (m_fill[cur] < m_spb) begin put_slot(cur, f, h); return 1; end
      end
      if (m_fill[cur] < PHYS_SLOTS) begin put_slot(cur, f, h); return 1; end
      return 0;
   endfunction

   function automatic bit grow_table();
      int n;
      bit ok;
      n = 0;
      ok = 1;
      for (int b = 0; b < m_nbk; b++)
         for (int s = 0; s < m_fill[b]; s++) m_scr[n++] = m_hash[b*PHYS_SLOTS + s];
      m_nbk *= 2;
      foreach (m_fill[b]) m_fill[b] = 0;
      m_items = 0;
      for (int i = 0; i < n; i++)
         if (place_kick(m_scr[i])) m_items++;
         else ok = 0;
      return ok;
   endfunction

   function automatic void model_csr(logic [CSR_AW-1:0] a, logic [CSR_DW-1:0] d);
      int v;
      case (a)
         CFG_INIT_BUCKETS: begin
            v = int'(d[8:0]);
            if (v == 0) v = 1;
            if (v > MAX_BUCKETS) v = MAX_BUCKETS;
            m_init = v;
            m_nbk = v;
            m_items = 0;
            foreach (m_fill[b]) m_fill[b] = 0;
         end
         CFG_SLOTS: begin
            v = int'(d[3:0]);
            if (v == 0) v = 1;
            if (v > PHYS_SLOTS) v = PHYS_SLOTS;
            m_spb = v;
         end
         CFG_THRESHOLD: m_thr = (d == 0) ? 1 : int'(d);
         CFG_MAX_KICKS: m_kicks = int'(d[9:0]);
         default: ;
      endcase
   endfunction

   function automatic void model_byte(pend_type p);
      result_type r;
      logic [HASH_W-1:0] h;
      logic [FP_W-1:0] f;
      int i1;
      bit go;
      if (p.bvalid) m_acc = (m_acc ^ 64'(p.kbyte)) * 64'h100000001b3;
      if (!p.tlast) return;
      h = m_acc;
      m_acc = FNV_BASIS;
      r = '0;
      f = fprint(h);
      i1 = home_bkt(h);
      r.found = bkt_has(i1, f) || bkt_has(other_bkt(i1, f), f);
      if (p.func && !r.found) begin
         go = 1;
         if (longint'(m_items) * 256 >= longint'(m_thr) * m_nbk * m_spb) begin
            if (m_nbk * 2 > MAX_BUCKETS) begin
               r.overflow = 1;
               go = 0;
            end else begin
               r.expanded = 1;
               if (!grow_table()) r.overflow = 1;
            end
         end
         if (go) begin
            if (place_kick(h)) begin
               r.inserted = 1;
               m_items++;
            end else r.overflow = 1;
         end
      end
      r.item_count = ITEM_W'(m_items);
      r.bucket_count = CNT_W'(m_nbk);
      want_q.insert(want_q.size(), r);
   endfunction

   // driver
   always @(posedge clock) begin
      pend_type p;
      bit busy, nv, nogap;
      if (reset) begin
         req_tvalid <= 0;
         csr_we <= 0;
         quiet = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            p.kind = K_BYTE;
            p.kbyte = req_tdata;
            p.func = req_tuser[0];
            p.bvalid = req_tuser[1];
            p.tlast = req_tlast;
            model_byte(p);
            n_acc++;
         end
         busy = req_tvalid && !req_tready;
         nogap = (n_acc % 400) >= 300;
         csr_we <= 0;
         if (!busy) begin
            nv = 0;
            if (pend_q.size() != 0) begin
               if (pend_q[0].kind == K_BYTE) begin
                  quiet = 0;
                  if (nogap || $urandom_range(99) >= 13) begin
                     p = pend_q.pop_front();
                     req_tdata <= p.kbyte;
                     req_tuser <= {p.bvalid, p.func};
                     req_tlast <= p.tlast;
                     nv = 1;
                  end
               end else if (want_q.size() == 0 && !req_tvalid) begin
                  if (++quiet >= QUIET_CYC) begin
                     p = pend_q.pop_front();
                     quiet = 0;
                     if (p.kind == K_CFG) begin
                        csr_we <= 1;
                        csr_addr <= p.addr;
                        csr_wdata <= p.data;
                        model_csr(p.addr, p.data);
                     end
                  end
               end else quiet = 0;
            end else stim_done = 1;
            req_tvalid <= nv;
         end
      end
   end

   // monitor
   int hold_left;
   bit held_once;
   always @(posedge clock) begin
      result_type got, w;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[24:0]);
            if (want_q.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected transaction: %p", got);
            end else begin
               w = want_q.pop_front();
               if (got !== w) begin
                  n_err++;
                  if (n_err <= 10) $display("mismatch: expected %p actual %p", w, got);
               end
            end
         end
         if (!held_once && n_acc >= 250) begin
            held_once = 1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else
            rsp_tready <= ((n_acc % 400) >= 300) || ($urandom_range(99) >= 13);
      end
   end

   // watchdog
   int stuck;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stuck = 0;
      else if (++stuck >= WDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // key pool for repeats
   logic [7:0] pool_b[$][$];

   task automatic add_cfg(logic [CSR_AW-1:0] a, logic [CSR_DW-1:0] d);
      pend_type p;
      p = '{K_CFG, 8'd0, 1'b0, 1'b0, 1'b0, a, d};
      pend_q.insert(pend_q.size(), p);
   endtask

   task automatic add_key(logic fn, logic [7:0] kb[$], bit gaps);
      pend_type p;
      p = '{K_BYTE, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0};
      if (kb.size() == 0) begin
         p.func = fn;
         p.tlast = 1;
         p.kbyte = 8'($urandom);
         pend_q.insert(pend_q.size(), p);
         return;
      end
      foreach (kb[i]) begin
         p.kbyte = kb[i];
         p.bvalid = gaps ? ($urandom_range(7) != 0) : 1'b1;
         p.tlast = (i == kb.size() - 1);
         p.func = p.tlast ? fn : 1'($urandom);
         pend_q.insert(pend_q.size(), p);
      end
   endtask

   task automatic add_random(int n_bytes);
      logic [7:0] kb[$];
      int start, len;
      pend_type d;
      start = pend_q.size();
      while (pend_q.size() - start < n_bytes) begin
         kb = {};
         if (pool_b.size() != 0 && $urandom_range(99) < 30)
            kb = pool_b[$urandom_range(pool_b.size() - 1)];
         else begin
            len = $urandom_range(4);
            repeat (len)
               kb.insert(kb.size(),
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
            pool_b.insert(pool_b.size(), kb);
         end
         add_key(($urandom_range(99) < 65), kb, $urandom_range(9) == 0);
      end
      d = '{K_DRAIN, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0};
      pend_q.insert(pend_q.size(), d);
   endtask

   initial begin
      logic [7:0] kb[$];
      pend_type p;
      n_err = 0;
      n_acc = 0;
      stim_done = 0;
      held_once = 0;
      hold_left = 0;
      stuck = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      req_tlast = 0;
      rsp_tready = 0;
      csr_we = 0;
      csr_addr = 0;
      csr_wdata = 0;
      m_init = 64; m_spb = 4; m_thr = 243; m_kicks = 500;
      m_nbk = 64; m_items = 0;
      foreach (m_fill[b]) m_fill[b] = 0;
      m_acc = FNV_BASIS;
      m_lfsr = LFSR_SEED;

      // directed: empty keys, byte extremes, skipped bytes, repeats
      add_key(1'b0, kb, 0);
      add_key(1'b1, kb, 0);
      add_key(1'b1, kb, 0);
      kb = {8'h00};              add_key(1'b1, kb, 0);
      kb = {8'hFF};              add_key(1'b1, kb, 0);
      kb = {8'hFF};              add_key(1'b0, kb, 0);
      kb = {8'h00, 8'hFF, 8'hA5}; add_key(1'b0, kb, 0);
      add_key(1'b1, kb, 0);
      add_key(1'b0, kb, 0);
      kb = {8'h5A, 8'hC3, 8'h3C, 8'h96}; add_key(1'b1, kb, 1);
      p = '{K_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, '0, '0};
      pend_q.insert(pend_q.size(), p);
      p = '{K_BYTE, 8'h12, 1'b0, 1'b1, 1'b1, '0, '0};
      pend_q.insert(pend_q.size(), p);
      p = '{K_DRAIN, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0};
      pend_q.insert(pend_q.size(), p);

      add_cfg(CFG_INIT_BUCKETS, 11'd1);
      add_cfg(CFG_SLOTS, 11'd1);
      add_cfg(CFG_THRESHOLD, 11'd1024);
      add_cfg(CFG_MAX_KICKS, 11'd0);
      add_random(60);

      add_cfg(CFG_INIT_BUCKETS, 11'd2);
      add_cfg(CFG_SLOTS, 11'd15);
      add_cfg(CFG_THRESHOLD, 11'd0);
      add_cfg(CFG_MAX_KICKS, 11'd1023);
      add_random(80);

      add_cfg(CFG_INIT_BUCKETS, 11'h7FF);
      add_cfg(CFG_SLOTS, 11'd0);
      add_cfg(CFG_THRESHOLD, 11'd1024);
      add_cfg(CFG_MAX_KICKS, 11'd3);
      add_random(250);

      add_cfg(CFG_INIT_BUCKETS, 11'd0);
      add_cfg(CFG_SLOTS, 11'd4);
      add_cfg(CFG_THRESHOLD, 11'd243);
      add_cfg(CFG_MAX_KICKS, 11'd20);
      add_random(250);

      add_cfg(CFG_INIT_BUCKETS, 11'd16);
      add_cfg(CFG_SLOTS, 11'd2);
      add_cfg(CFG_THRESHOLD, 11'd200);
      add_cfg(CFG_MAX_KICKS, 11'd40);
      add_random(150);

      repeat (11) @(posedge clock);
      reset <= 0;

      wait (stim_done);
      while (want_q.size() != 0 || req_tvalid) @(posedge clock);
      repeat (QUIET_CYC) @(posedge clock);
      if (n_err == 0 && want_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
